### rtl/ire_pkg.sv
// shared types and constants of the input rate estimator
package ire_pkg;

	localparam int unsigned TIME_BITS_DEF = 48;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned LIMIT_W = 16;
	localparam int unsigned RATE_W = 31;
	localparam int unsigned HDR_W = 8;
	localparam int unsigned PKT_IN_W = 16;
	localparam int unsigned BYTE_IN_W = 20;
	localparam int unsigned PKT_W = 32;
	localparam int unsigned BYTE_W = 48;
	localparam int unsigned MUL_A_W = 48;
	localparam int unsigned MUL_B_W = 20;
	localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;
	localparam int unsigned CFG_W = 31;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [MUL_B_W-1:0] US_PER_S = 20'd1000000;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [PKT_W-1:0] PKT_MAX = {PKT_W{1'b1}};
	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

	localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 24'd500000;
	localparam logic [PERIOD_W-1:0] RUN_PERIOD_RST = 24'd1000000;
	localparam logic [LIMIT_W-1:0] EARLY_LIMIT_RST = 16'd2000;
	localparam logic [RATE_W-1:0] INIT_RATE_RST = 31'd125000000;
	localparam logic [HDR_W-1:0] HDR_BYTES_RST = 8'd44;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_PERIOD = 3'd0,
		REG_RUN_PERIOD = 3'd1,
		REG_EARLY_LIMIT = 3'd2,
		REG_INIT_RATE = 3'd3,
		REG_HDR_BYTES = 3'd4
	} ire_reg_t;

endpackage

### rtl/ire_mul.sv
// bit-serial shift-add multiplier, one multiplier bit per cycle msb first
module ire_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ire_pkg::MUL_A_W-1:0] a,
	input  logic [ire_pkg::MUL_B_W-1:0] b,
	output logic [ire_pkg::PROD_W-1:0]  prod,
	output logic                        done
);
	import ire_pkg::*;

	localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);

	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [PROD_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [PROD_W-1:0] addend;

	always_comb begin
		addend = b_q[MUL_B_W-1] ? {{(PROD_W-MUL_A_W){1'b0}}, a_q} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PROD_W-2:0], 1'b0} + addend;
			b_q <= {b_q[MUL_B_W-2:0], 1'b0};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

### rtl/ire_div.sv
// bit-serial restoring divider with saturating quotient
module ire_div #(
	parameter int unsigned TIME_BITS = ire_pkg::TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ire_pkg::PROD_W-1:0] num,
	input  logic [TIME_BITS-1:0]       den,
	output logic [ire_pkg::RATE_W-1:0] quo,
	output logic                       done
);
	import ire_pkg::*;

	localparam int unsigned CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] num_q;
	logic [TIME_BITS-1:0] den_q;
	logic [TIME_BITS-1:0] rem_q;
	logic [RATE_W-1:0] q_q;
	logic ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [TIME_BITS:0] trial;
	logic [TIME_BITS+1:0] diff;
	logic ge;

	always_comb begin
		trial = {rem_q, num_q[PROD_W-1]};
		diff = {1'b0, trial} - {2'b00, den_q};
		ge = !diff[TIME_BITS+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(PROD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			q_q <= {q_q[RATE_W-2:0], ge};
			ovf_q <= ovf_q | q_q[RATE_W-1];
		end
	end

	assign quo = ovf_q ? RATE_MAX : q_q;
	assign done = done_q;

endmodule

### rtl/input_rate_estimator.sv
// top level of the input rate estimator: window control, totals and result register
//
// Each accepted report passes through accept, evaluate and window check when it
// does not close a window, and through accept and evaluate only when it is ignored
// or only opens the window. A report that closes the window runs the bit-serial
// datapath: a 20-step shift-add multiplier used twice (header bytes, then scaling
// by one million) and a 68-step restoring divider. The result goes to an output
// register, so the next report is taken while a result still waits; a new result
// waits in turn until the previous one has been taken. Writing start_period_us
// reloads the current period and writing initial_rate reloads the reported rate;
// the user must write registers only while the block is idle; nothing enforces it.
module input_rate_estimator #(
	parameter int unsigned TIME_BITS = ire_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [ire_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ire_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [TIME_BITS-1:0]          time_us,
	input  logic [ire_pkg::PKT_IN_W-1:0]  pkt_delta,
	input  logic [ire_pkg::BYTE_IN_W-1:0] byte_delta,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ire_pkg::RATE_W-1:0]    rate_bytes_per_s,
	output logic                          rate_updated
);
	import ire_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		ACC,
		CHECK,
		MULH,
		MULS,
		DIV,
		EMIT
	} state_t;

	state_t state_q;

	logic [PERIOD_W-1:0] run_period_q;
	logic [LIMIT_W-1:0] early_limit_q;
	logic [HDR_W-1:0] hdr_bytes_q;

	logic window_open_q;
	logic [TIME_BITS-1:0] window_start_q;
	logic [PKT_W-1:0] pkt_total_q;
	logic [BYTE_W-1:0] byte_total_q;
	logic [PERIOD_W-1:0] cur_period_q;
	logic [RATE_W-1:0] rate_value_q;

	logic [TIME_BITS-1:0] t_q;
	logic [PKT_IN_W-1:0] pk_q;
	logic [BYTE_IN_W-1:0] by_q;
	logic [TIME_BITS-1:0] elapsed_q;
	logic res_upd_q;

	logic result_valid_q;
	logic [RATE_W-1:0] rate_q;
	logic upd_q;
	logic mul_start_q;
	logic div_start_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0] mul_prod;
	logic mul_done;
	logic [TIME_BITS-1:0] div_den;
	logic [RATE_W-1:0] div_quo;
	logic div_done;

	logic [PKT_W:0] pkt_sum;
	logic [BYTE_W:0] byte_sum;
	logic [BYTE_W:0] hdr_sum;
	logic [TIME_BITS:0] tdiff;
	logic t_ge;
	logic early;
	logic close_win;
	logic out_free;
	logic skip;

	always_comb begin
		pkt_sum = {1'b0, pkt_total_q} + {{(PKT_W+1-PKT_IN_W){1'b0}}, pk_q};
		byte_sum = {1'b0, byte_total_q} + {{(BYTE_W+1-BYTE_IN_W){1'b0}}, by_q};
		hdr_sum = {1'b0, byte_total_q} + {1'b0, mul_prod[BYTE_W-1:0]};
		tdiff = {1'b0, t_q} - {1'b0, window_start_q};
		t_ge = !tdiff[TIME_BITS];
		skip = (cur_period_q == '0) || !window_open_q || !t_ge;
		early = (cur_period_q < run_period_q)
			&& (pkt_total_q > {{(PKT_W-LIMIT_W){1'b0}}, early_limit_q});
		close_win = early
			|| (elapsed_q > {{(TIME_BITS-PERIOD_W){1'b0}}, cur_period_q});
		out_free = !result_valid_q || !result_stall;
		div_den = (elapsed_q == '0) ? {{(TIME_BITS-1){1'b0}}, 1'b1} : elapsed_q;
		if (state_q == MULS) begin
			mul_a = byte_total_q;
			mul_b = US_PER_S;
		end else begin
			mul_a = {{(MUL_A_W-PKT_W){1'b0}}, pkt_total_q};
			mul_b = {{(MUL_B_W-HDR_W){1'b0}}, hdr_bytes_q};
		end
	end

	ire_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	ire_div #(
		.TIME_BITS (TIME_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (mul_prod),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// captured transaction and elapsed time
	always_ff @(posedge clk) begin
		if (state_q == IDLE && item_valid) begin
			t_q <= time_us;
			pk_q <= pkt_delta;
			by_q <= byte_delta;
		end
		if (state_q == ACC) begin
			elapsed_q <= tdiff[TIME_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			run_period_q <= RUN_PERIOD_RST;
			early_limit_q <= EARLY_LIMIT_RST;
			hdr_bytes_q <= HDR_BYTES_RST;
			window_open_q <= 1'b0;
			window_start_q <= '0;
			pkt_total_q <= '0;
			byte_total_q <= '0;
			cur_period_q <= START_PERIOD_RST;
			rate_value_q <= INIT_RATE_RST;
			res_upd_q <= 1'b0;
			result_valid_q <= 1'b0;
			rate_q <= '0;
			upd_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (item_valid) begin
						state_q <= ACC;
					end
				end
				ACC: begin
					if (skip) begin
						if (cur_period_q != '0 && !window_open_q) begin
							window_open_q <= 1'b1;
							window_start_q <= t_q;
						end
						if (out_free) begin
							result_valid_q <= 1'b1;
							rate_q <= rate_value_q;
							upd_q <= 1'b0;
							state_q <= IDLE;
						end else begin
							res_upd_q <= 1'b0;
							state_q <= EMIT;
						end
					end else begin
						pkt_total_q <= pkt_sum[PKT_W] ? PKT_MAX : pkt_sum[PKT_W-1:0];
						byte_total_q <= byte_sum[BYTE_W] ? BYTE_MAX : byte_sum[BYTE_W-1:0];
						state_q <= CHECK;
					end
				end
				CHECK: begin
					if (close_win) begin
						mul_start_q <= 1'b1;
						state_q <= MULH;
					end else if (out_free) begin
						result_valid_q <= 1'b1;
						rate_q <= rate_value_q;
						upd_q <= 1'b0;
						state_q <= IDLE;
					end else begin
						res_upd_q <= 1'b0;
						state_q <= EMIT;
					end
				end
				MULH: begin
					if (mul_done) begin
						byte_total_q <= hdr_sum[BYTE_W] ? BYTE_MAX : hdr_sum[BYTE_W-1:0];
						mul_start_q <= 1'b1;
						state_q <= MULS;
					end
				end
				MULS: begin
					if (mul_done) begin
						div_start_q <= 1'b1;
						state_q <= DIV;
					end
				end
				DIV: begin
					if (div_done) begin
						rate_value_q <= div_quo;
						pkt_total_q <= '0;
						byte_total_q <= '0;
						window_start_q <= t_q;
						cur_period_q <= run_period_q;
						res_upd_q <= 1'b1;
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						rate_q <= rate_value_q;
						upd_q <= res_upd_q;
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (cfg_wen) begin
				unique case (ire_reg_t'(cfg_index))
					REG_START_PERIOD: begin
						cur_period_q <= cfg_data[PERIOD_W-1:0];
					end
					REG_RUN_PERIOD: begin
						run_period_q <= cfg_data[PERIOD_W-1:0];
					end
					REG_EARLY_LIMIT: begin
						early_limit_q <= cfg_data[LIMIT_W-1:0];
					end
					REG_INIT_RATE: begin
						rate_value_q <= cfg_data[RATE_W-1:0];
					end
					REG_HDR_BYTES: begin
						hdr_bytes_q <= cfg_data[HDR_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign item_stall = (state_q != IDLE);
	assign result_valid = result_valid_q;
	assign rate_bytes_per_s = rate_q;
	assign rate_updated = upd_q;

endmodule
